### rtl/infix_expression_evaluator_defines.svh
// ----------------------------------------------------------------------------
// Infix expression evaluator - assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef INFIX_EXPRESSION_EVALUATOR_DEFINES_SVH
`define INFIX_EXPRESSION_EVALUATOR_DEFINES_SVH

// same-cycle implication
`define IEE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define IEE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/iee_pkg.sv
// ----------------------------------------------------------------------------
// Infix expression evaluator - package
// Widths, character codes, operator and error codes, and the ALU interface.
// ----------------------------------------------------------------------------
`default_nettype none

package iee_pkg;

    localparam int VAL_W        = 48;
    localparam int ERR_W        = 2;
    localparam int CHAR_W       = 8;
    localparam int OUT_TDATA_W  = 56;

    localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;
    localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

    typedef enum logic [2:0] {
        OP_ADD   = 3'd0,
        OP_SUB   = 3'd1,
        OP_MUL   = 3'd2,
        OP_DIV   = 3'd3,
        OP_OTHER = 3'd4
    } op_t;

    typedef enum logic [ERR_W-1:0] {
        ERR_NONE     = 2'd0,
        ERR_DIV_ZERO = 2'd1,
        ERR_STACK    = 2'd2,
        ERR_OVERFLOW = 2'd3
    } err_t;

    typedef struct packed {
        logic start;
        op_t  op;
    } alu_req_t;

    typedef struct packed {
        logic done;
        err_t err;
    } alu_rsp_t;

    function automatic logic op_high(op_t op);
        return (op != OP_ADD) && (op != OP_SUB);
    endfunction

    function automatic op_t char_to_op(logic [CHAR_W-1:0] c);
        op_t op;
        unique case (c)
            CH_PLUS:  op = OP_ADD;
            CH_MINUS: op = OP_SUB;
            CH_STAR:  op = OP_MUL;
            CH_SLASH: op = OP_DIV;
            default:  op = OP_OTHER;
        endcase
        return op;
    endfunction

endpackage

`default_nettype wire

### rtl/iee_alu.sv
// ----------------------------------------------------------------------------
// Infix expression evaluator - shared arithmetic unit
// Saturating fixed-point add, subtract, bit-serial multiply and restoring
// divide on 48-bit signed words.
// ----------------------------------------------------------------------------
`default_nettype none
`include "infix_expression_evaluator_defines.svh"

module iee_alu #(
    parameter int FRACTION_BITS = 16
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire iee_pkg::alu_req_t                 req,
    input  wire logic signed [iee_pkg::VAL_W-1:0]  x,
    input  wire logic signed [iee_pkg::VAL_W-1:0]  y,
    output iee_pkg::alu_rsp_t                      rsp,
    output logic signed [iee_pkg::VAL_W-1:0]       result
);

    localparam int W      = iee_pkg::VAL_W;
    localparam int DW     = W + FRACTION_BITS;
    localparam int PW     = 2 * W;
    localparam int STEP_W = $clog2(DW + 1);

    typedef enum logic [1:0] {A_IDLE, A_MUL, A_DIV, A_FIN} alu_state_t;

    function automatic logic [W-1:0] magnitude(logic signed [W-1:0] v);
        return v[W-1] ? $unsigned(-v) : $unsigned(v);
    endfunction

    alu_state_t            state_reg, state_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic                  neg_reg, neg_next;
    logic                  mul_reg, mul_next;
    logic [W-1:0]          b_reg, b_next;
    logic [W-1:0]          hi_reg, hi_next;
    logic [DW-1:0]         qd_reg, qd_next;
    logic                  done_reg, done_next;
    iee_pkg::err_t         err_reg, err_next;
    logic signed [W-1:0]   res_reg, res_next;

    logic [W:0]            sum;
    logic [W:0]            rem_try;
    logic [W:0]            rem_sub;
    logic                  rem_ge;
    logic [W:0]            ext_x;
    logic [W:0]            ext_y;
    logic [W:0]            addsub;
    logic [PW-1:0]         full_mag;
    logic [W-1:0]          mag_lo;
    logic [W-1:0]          lim;
    logic                  sat;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        neg_next   = neg_reg;
        mul_next   = mul_reg;
        b_next     = b_reg;
        hi_next    = hi_reg;
        qd_next    = qd_reg;
        done_next  = 1'b0;
        err_next   = err_reg;
        res_next   = res_reg;

        sum     = {1'b0, hi_reg} + (qd_reg[0] ? {1'b0, b_reg} : {(W+1){1'b0}});
        rem_try = {hi_reg, qd_reg[DW-1]};
        rem_ge  = rem_try >= {1'b0, b_reg};
        rem_sub = rem_try - {1'b0, b_reg};

        ext_x  = {x[W-1], x};
        ext_y  = {y[W-1], y};
        addsub = (req.op == iee_pkg::OP_SUB) ? (ext_x - ext_y) : (ext_x + ext_y);

        full_mag = mul_reg ? ({hi_reg, qd_reg[W-1:0]} >> FRACTION_BITS) : PW'(qd_reg);
        mag_lo   = full_mag[W-1:0];
        lim      = neg_reg ? iee_pkg::VAL_MIN : iee_pkg::VAL_MAX;
        sat      = (|full_mag[PW-1:W]) || (mag_lo > lim);

        unique case (state_reg)
            A_IDLE:
            begin
                if (req.start)
                begin
                    neg_next  = x[W-1] ^ y[W-1];
                    b_next    = magnitude(y);
                    hi_next   = '0;
                    step_next = '0;
                    unique case (req.op)
                        iee_pkg::OP_ADD, iee_pkg::OP_SUB:
                        begin
                            done_next = 1'b1;
                            if (addsub[W] != addsub[W-1])
                            begin
                                err_next = iee_pkg::ERR_OVERFLOW;
                                res_next = addsub[W] ? iee_pkg::VAL_MIN : iee_pkg::VAL_MAX;
                            end
                            else
                            begin
                                err_next = iee_pkg::ERR_NONE;
                                res_next = $signed(addsub[W-1:0]);
                            end
                        end
                        iee_pkg::OP_MUL:
                        begin
                            mul_next   = 1'b1;
                            qd_next    = DW'(magnitude(x));
                            state_next = A_MUL;
                        end
                        iee_pkg::OP_DIV:
                        begin
                            if (y == '0)
                            begin
                                done_next = 1'b1;
                                err_next  = iee_pkg::ERR_DIV_ZERO;
                                res_next  = '0;
                            end
                            else
                            begin
                                mul_next   = 1'b0;
                                qd_next    = DW'(magnitude(x)) << FRACTION_BITS;
                                state_next = A_DIV;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                            err_next  = iee_pkg::ERR_NONE;
                            res_next  = '0;
                        end
                    endcase
                end
            end
            A_MUL:
            begin
                hi_next         = sum[W:1];
                qd_next[W-1:0]  = {sum[0], qd_reg[W-1:1]};
                step_next       = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(W - 1))
                    state_next = A_FIN;
            end
            A_DIV:
            begin
                hi_next   = rem_ge ? rem_sub[W-1:0] : rem_try[W-1:0];
                qd_next   = {qd_reg[DW-2:0], rem_ge};
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(DW - 1))
                    state_next = A_FIN;
            end
            A_FIN:
            begin
                done_next  = 1'b1;
                state_next = A_IDLE;
                if (sat)
                begin
                    err_next = iee_pkg::ERR_OVERFLOW;
                    res_next = neg_reg ? iee_pkg::VAL_MIN : iee_pkg::VAL_MAX;
                end
                else
                begin
                    err_next = iee_pkg::ERR_NONE;
                    res_next = neg_reg ? $signed(-mag_lo) : $signed(mag_lo);
                end
            end
            default:
                state_next = A_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= A_IDLE;
            step_reg  <= '0;
            neg_reg   <= 1'b0;
            mul_reg   <= 1'b0;
            b_reg     <= '0;
            hi_reg    <= '0;
            qd_reg    <= '0;
            done_reg  <= 1'b0;
            err_reg   <= iee_pkg::ERR_NONE;
            res_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            neg_reg   <= neg_next;
            mul_reg   <= mul_next;
            b_reg     <= b_next;
            hi_reg    <= hi_next;
            qd_reg    <= qd_next;
            done_reg  <= done_next;
            err_reg   <= err_next;
            res_reg   <= res_next;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.err  = err_reg;
    assign result   = res_reg;

    `IEE_ASSERT_NOW(a_start_when_idle, req.start, state_reg == A_IDLE, "ALU started while busy")
    `IEE_ASSERT_NEXT(a_fin_gives_done, state_reg == A_FIN, rsp.done, "ALU finish without done")

endmodule

`default_nettype wire

### rtl/infix_expression_evaluator.sv
// ----------------------------------------------------------------------------
// Infix expression evaluator
// Two-stack operator-precedence evaluation of + - * / expressions in 48-bit
// signed fixed point.
//
// Input words carry one ASCII character in s_tdata[7:0]; s_tlast marks the
// last character of an expression. One output word is produced per
// expression: m_tdata[47:0] value, m_tdata[49:48] error code.
// s_tready is high only while the sequencer is idle; one word is in work at
// a time. A digit or space passes decode and the last-word check. An operator
// also passes the precedence check, with one reduction per stacked operator
// it pops. A reduction pops the operator and two operands, then waits on the
// shared ALU, which adds or subtracts directly, gives zero for other, and
// multiplies and divides bit-serially. The last word also runs its pending
// reductions; the bit-serial ALU sets the cost of a word.
// The result sits in an output register; the block keeps taking words while
// it waits and only holds at the end of the next expression if the previous
// result has still not been taken. Reset empties both stacks, clears the
// error and drops any pending result.
// ----------------------------------------------------------------------------
`default_nettype none
`include "infix_expression_evaluator_defines.svh"

module infix_expression_evaluator #(
    parameter int STACK_DEPTH   = 4,
    parameter int FRACTION_BITS = 16
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [iee_pkg::CHAR_W-1:0]          s_tdata,   // [7:0] char_code
    input  wire logic                                s_tlast,   // end_of_expression
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [iee_pkg::OUT_TDATA_W-1:0]          m_tdata    // value, error_code, pad
);

    localparam int W     = iee_pkg::VAL_W;
    localparam int CNT_W = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W = $clog2(STACK_DEPTH);
    localparam int ACC_W = W + 4;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_PREC,
        S_REDUCE,
        S_POP_Y,
        S_POP_X,
        S_ALU_WAIT,
        S_LAST,
        S_FINAL
    } state_t;

    state_t                          state_reg, state_next;
    logic [iee_pkg::CHAR_W-1:0]      char_reg, char_next;
    logic                            last_reg, last_next;
    iee_pkg::op_t                    new_op_reg, new_op_next;
    iee_pkg::op_t                    alu_op_reg, alu_op_next;
    logic                            ret_final_reg, ret_final_next;
    logic [CNT_W-1:0]                opnd_cnt_reg, opnd_cnt_next;
    logic [CNT_W-1:0]                oper_cnt_reg, oper_cnt_next;
    logic [W-1:0]                    acc_reg, acc_next;
    logic                            in_num_reg, in_num_next;
    iee_pkg::err_t                   sticky_reg, sticky_next;
    logic signed [W-1:0]             y_reg, y_next;
    logic                            out_valid_reg, out_valid_next;
    logic signed [W-1:0]             out_value_reg, out_value_next;
    iee_pkg::err_t                   out_err_reg, out_err_next;

    logic signed [W-1:0]             opnd_stack_reg [STACK_DEPTH];
    iee_pkg::op_t                    oper_stack_reg [STACK_DEPTH];

    logic [CNT_W-1:0]                opnd_cnt_m1;
    logic [CNT_W-1:0]                oper_cnt_m1;
    logic signed [W-1:0]             opnd_top;
    iee_pkg::op_t                    oper_top;
    state_t                          ret_state;

    logic                            push_req;
    logic signed [W-1:0]             push_data;
    logic [CNT_W-1:0]                push_base;
    logic                            opnd_wr_en;
    logic [IDX_W-1:0]                opnd_wr_idx;
    logic                            oper_wr_en;
    iee_pkg::err_t                   flag;

    logic                            is_digit;
    logic [ACC_W-1:0]                acc_new;
    logic                            acc_ovf;

    iee_pkg::alu_req_t               alu_req;
    iee_pkg::alu_rsp_t               alu_rsp;
    logic signed [W-1:0]             alu_result;

    assign opnd_cnt_m1 = opnd_cnt_reg - CNT_W'(1);
    assign oper_cnt_m1 = oper_cnt_reg - CNT_W'(1);
    assign opnd_top    = opnd_stack_reg[opnd_cnt_m1[IDX_W-1:0]];
    assign oper_top    = oper_stack_reg[oper_cnt_m1[IDX_W-1:0]];
    assign ret_state   = ret_final_reg ? S_FINAL : S_PREC;

    assign is_digit = (char_reg >= iee_pkg::CH_ZERO) && (char_reg <= iee_pkg::CH_NINE);
    // acc * 10 + digit, digit placed at the binary point
    assign acc_new  = (ACC_W'(acc_reg) << 3) + (ACC_W'(acc_reg) << 1)
                    + (ACC_W'(char_reg - iee_pkg::CH_ZERO) << FRACTION_BITS);
    assign acc_ovf  = acc_new > ACC_W'(iee_pkg::VAL_MAX);

    always_comb
    begin
        state_next     = state_reg;
        char_next      = char_reg;
        last_next      = last_reg;
        new_op_next    = new_op_reg;
        alu_op_next    = alu_op_reg;
        ret_final_next = ret_final_reg;
        opnd_cnt_next  = opnd_cnt_reg;
        oper_cnt_next  = oper_cnt_reg;
        acc_next       = acc_reg;
        in_num_next    = in_num_reg;
        sticky_next    = sticky_reg;
        y_next         = y_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_value_next = out_value_reg;
        out_err_next   = out_err_reg;

        push_req    = 1'b0;
        push_data   = '0;
        push_base   = opnd_cnt_reg;
        opnd_wr_en  = 1'b0;
        opnd_wr_idx = '0;
        oper_wr_en  = 1'b0;
        flag        = iee_pkg::ERR_NONE;
        alu_req     = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    char_next  = s_tdata;
                    last_next  = s_tlast;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (is_digit)
                begin
                    acc_next    = acc_ovf ? iee_pkg::VAL_MAX : acc_new[W-1:0];
                    in_num_next = 1'b1;
                    if (acc_ovf)
                        flag = iee_pkg::ERR_OVERFLOW;
                    state_next = S_LAST;
                end
                else
                begin
                    if (in_num_reg)
                    begin
                        push_req    = 1'b1;
                        push_data   = $signed(acc_reg);
                        acc_next    = '0;
                        in_num_next = 1'b0;
                    end
                    if (char_reg == iee_pkg::CH_SPACE)
                        state_next = S_LAST;
                    else
                    begin
                        new_op_next = iee_pkg::char_to_op(char_reg);
                        state_next  = S_PREC;
                    end
                end
            end
            S_PREC:
            begin
                if ((oper_cnt_reg != '0) &&
                    (!iee_pkg::op_high(new_op_reg) || iee_pkg::op_high(oper_top)))
                begin
                    ret_final_next = 1'b0;
                    state_next     = S_REDUCE;
                end
                else
                begin
                    if (oper_cnt_reg < CNT_W'(STACK_DEPTH))
                    begin
                        oper_wr_en    = 1'b1;
                        oper_cnt_next = oper_cnt_reg + CNT_W'(1);
                    end
                    else
                        flag = iee_pkg::ERR_STACK;
                    state_next = S_LAST;
                end
            end
            S_REDUCE:
            begin
                alu_op_next   = oper_top;
                oper_cnt_next = oper_cnt_m1;
                if (opnd_cnt_reg < CNT_W'(2))
                begin
                    // too few operands: drop them and stand a zero in their place
                    flag       = iee_pkg::ERR_STACK;
                    push_req   = 1'b1;
                    push_base  = '0;
                    push_data  = '0;
                    state_next = ret_state;
                end
                else
                    state_next = S_POP_Y;
            end
            S_POP_Y:
            begin
                y_next        = opnd_top;
                opnd_cnt_next = opnd_cnt_m1;
                state_next    = S_POP_X;
            end
            S_POP_X:
            begin
                alu_req.start = 1'b1;
                alu_req.op    = alu_op_reg;
                opnd_cnt_next = opnd_cnt_m1;
                state_next    = S_ALU_WAIT;
            end
            S_ALU_WAIT:
            begin
                if (alu_rsp.done)
                begin
                    push_req   = 1'b1;
                    push_data  = alu_result;
                    flag       = alu_rsp.err;
                    state_next = ret_state;
                end
            end
            S_LAST:
            begin
                if (last_reg)
                begin
                    if (in_num_reg)
                    begin
                        push_req    = 1'b1;
                        push_data   = $signed(acc_reg);
                        acc_next    = '0;
                        in_num_next = 1'b0;
                    end
                    state_next = S_FINAL;
                end
                else
                    state_next = S_IDLE;
            end
            S_FINAL:
            begin
                if (oper_cnt_reg != '0)
                begin
                    ret_final_next = 1'b1;
                    state_next     = S_REDUCE;
                end
                else if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    if (opnd_cnt_reg == '0)
                    begin
                        out_value_next = '0;
                        out_err_next   = (sticky_reg == iee_pkg::ERR_NONE) ?
                                         iee_pkg::ERR_STACK : sticky_reg;
                    end
                    else
                    begin
                        out_value_next = opnd_top;
                        out_err_next   = sticky_reg;
                    end
                    opnd_cnt_next = '0;
                    oper_cnt_next = '0;
                    acc_next      = '0;
                    in_num_next   = 1'b0;
                    sticky_next   = iee_pkg::ERR_NONE;
                    state_next    = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase

        if (push_req)
        begin
            if (push_base < CNT_W'(STACK_DEPTH))
            begin
                opnd_wr_en    = 1'b1;
                opnd_wr_idx   = push_base[IDX_W-1:0];
                opnd_cnt_next = push_base + CNT_W'(1);
            end
            else
                flag = iee_pkg::ERR_STACK;
        end

        if ((sticky_reg == iee_pkg::ERR_NONE) && (flag != iee_pkg::ERR_NONE))
            sticky_next = flag;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            char_reg      <= '0;
            last_reg      <= 1'b0;
            new_op_reg    <= iee_pkg::OP_ADD;
            alu_op_reg    <= iee_pkg::OP_ADD;
            ret_final_reg <= 1'b0;
            opnd_cnt_reg  <= '0;
            oper_cnt_reg  <= '0;
            acc_reg       <= '0;
            in_num_reg    <= 1'b0;
            sticky_reg    <= iee_pkg::ERR_NONE;
            y_reg         <= '0;
            out_valid_reg <= 1'b0;
            out_value_reg <= '0;
            out_err_reg   <= iee_pkg::ERR_NONE;
        end
        else
        begin
            state_reg     <= state_next;
            char_reg      <= char_next;
            last_reg      <= last_next;
            new_op_reg    <= new_op_next;
            alu_op_reg    <= alu_op_next;
            ret_final_reg <= ret_final_next;
            opnd_cnt_reg  <= opnd_cnt_next;
            oper_cnt_reg  <= oper_cnt_next;
            acc_reg       <= acc_next;
            in_num_reg    <= in_num_next;
            sticky_reg    <= sticky_next;
            y_reg         <= y_next;
            out_valid_reg <= out_valid_next;
            out_value_reg <= out_value_next;
            out_err_reg   <= out_err_next;
        end
    end

    // stack contents are only read below the count
    always_ff @(posedge clk)
    begin
        if (opnd_wr_en)
            opnd_stack_reg[opnd_wr_idx] <= push_data;
        if (oper_wr_en)
            oper_stack_reg[oper_cnt_reg[IDX_W-1:0]] <= new_op_reg;
    end

    iee_alu #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_alu (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (alu_req),
        .x      (opnd_top),
        .y      (y_reg),
        .rsp    (alu_rsp),
        .result (alu_result)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(iee_pkg::OUT_TDATA_W - W - iee_pkg::ERR_W){1'b0}},
                       out_err_reg, out_value_reg};

    `IEE_ASSERT_NOW(a_alu_done_in_wait, alu_rsp.done, state_reg == S_ALU_WAIT, "ALU result outside wait")
    `IEE_ASSERT_NEXT(a_accept_to_decode, s_tvalid && s_tready, state_reg == S_DECODE, "word not decoded")
    `IEE_ASSERT_NOW(a_counts_bounded, 1'b1, (opnd_cnt_reg <= CNT_W'(STACK_DEPTH)) && (oper_cnt_reg <= CNT_W'(STACK_DEPTH)), "stack count beyond depth")

endmodule

`default_nettype wire

### test/infix_expression_evaluator_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Infix expression evaluator - testbench
// Streams ASCII expressions into the block, character by character. Each
// accepted character is run through a local two-stack fixed-point evaluator.
// Each expression result that comes back is compared, value and error code,
// with the oldest prediction. Directed corner expressions come first. Random
// expressions follow, mostly well formed, some broken, some noise. Both sides
// of the stream stall at random at rates set per phase; the last phase has none.
// ----------------------------------------------------------------------------
module infix_expression_evaluator_test;

    import iee_pkg::*;

    localparam int     DEPTH       = 4;
    localparam int     FRAC        = 16;
    localparam int     CYCLE_LIMIT = 1000000;
    localparam int     TAIL_CYCLES = 400;
    localparam int     PHASE_WORDS = 150;
    localparam longint V_HI        = (longint'(1) <<< 47) - 1;
    localparam longint V_LO        = -V_HI - 1;

    localparam logic [CHAR_W-1:0] CH_HASH   = 8'h23;
    localparam logic [CHAR_W-1:0] CH_DOLLAR = 8'h24;
    localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;
    localparam logic [CHAR_W-1:0] CH_TOP    = 8'hFF;

    typedef struct {
        logic [CHAR_W-1:0] ch;
        logic              last;
        int                phase;
        bit                drain;
    } char_word_t;

    typedef struct {
        logic signed [VAL_W-1:0] value;
        err_t                    err;
    } expr_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [CHAR_W-1:0]      s_tdata = '0;   // [7:0] char_code
    logic                   s_tlast = 1'b0; // end_of_expression
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;        // [47:0] value, [49:48] error_code, pad

    char_word_t   char_queue[$];
    expr_result_t predicted_results[$];

    int phase = 0;
    int failures = 0;
    int chars_sent = 0;
    int results_checked = 0;
    int err_seen[4] = '{0, 0, 0, 0};
    int cycle_count = 0;

    // evaluator state
    longint            opnd_stk[DEPTH];
    int                opnd_cnt = 0;
    op_t               oper_stk[DEPTH];
    int                oper_cnt = 0;
    logic [63:0]       num_acc = '0;
    bit                num_open = 1'b0;
    err_t              first_err = ERR_NONE;

    infix_expression_evaluator #(
        .STACK_DEPTH   (DEPTH),
        .FRACTION_BITS (FRAC)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ---- evaluator ---------------------------------------------------------

    function automatic void note_error(err_t e);
        if (first_err == ERR_NONE)
            first_err = e;
    endfunction

    function automatic longint clamp_val(longint v);
        if (v > V_HI)
        begin
            note_error(ERR_OVERFLOW);
            return V_HI;
        end
        if (v < V_LO)
        begin
            note_error(ERR_OVERFLOW);
            return V_LO;
        end
        return v;
    endfunction

    function automatic logic [127:0] magnitude(longint v);
        return 128'(v < 0 ? -v : v);
    endfunction

    function automatic longint signed_fit(logic [127:0] m, bit neg);
        logic [127:0] lim;
        lim = neg ? (128'd1 << 47) : (128'd1 << 47) - 128'd1;
        if (m > lim)
        begin
            note_error(ERR_OVERFLOW);
            return neg ? V_LO : V_HI;
        end
        return neg ? -longint'(m[63:0]) : longint'(m[63:0]);
    endfunction

    function automatic int prio(op_t op);
        return (op == OP_ADD || op == OP_SUB) ? 2 : 3;
    endfunction

    function automatic void push_operand(longint v);
        if (opnd_cnt >= DEPTH)
            note_error(ERR_STACK);
        else
        begin
            opnd_stk[opnd_cnt] = v;
            opnd_cnt++;
        end
    endfunction

    function automatic void reduce_top();
        op_t    op;
        longint lhs;
        longint rhs;
        longint r;
        oper_cnt--;
        op = oper_stk[oper_cnt];
        if (opnd_cnt < 2)
        begin
            // missing operand: drop what is there, push zero
            note_error(ERR_STACK);
            opnd_cnt = 0;
            push_operand(0);
            return;
        end
        rhs = opnd_stk[opnd_cnt - 1];
        lhs = opnd_stk[opnd_cnt - 2];
        opnd_cnt -= 2;
        case (op)
            OP_ADD: r = clamp_val(lhs + rhs);
            OP_SUB: r = clamp_val(lhs - rhs);
            OP_MUL: r = signed_fit((magnitude(lhs) * magnitude(rhs)) >> FRAC,
                                   (lhs < 0) != (rhs < 0));
            OP_DIV:
                if (rhs == 0)
                begin
                    note_error(ERR_DIV_ZERO);
                    r = 0;
                end
                else
                    r = signed_fit((magnitude(lhs) << FRAC) / magnitude(rhs),
                                   (lhs < 0) != (rhs < 0));
            default: r = 0;
        endcase
        push_operand(r);
    endfunction

    function automatic void close_number();
        if (num_open)
        begin
            push_operand(longint'(num_acc));
            num_acc  = '0;
            num_open = 1'b0;
        end
    endfunction

    function automatic bit evaluate_char(input logic [CHAR_W-1:0] ch, input logic last,
                                         output expr_result_t res);
        logic [63:0] n;
        op_t         op;
        longint      v;
        v = 0;
        res.value = '0;
        res.err = ERR_NONE;
        if (ch >= CH_ZERO && ch <= CH_NINE)
        begin
            n = num_acc * 64'd10 + (64'(ch - CH_ZERO) << FRAC);
            if (n > 64'(V_HI))
            begin
                note_error(ERR_OVERFLOW);
                n = 64'(V_HI);
            end
            num_acc  = n;
            num_open = 1'b1;
        end
        else
        begin
            close_number();
            if (ch != CH_SPACE)
            begin
                case (ch)
                    CH_PLUS:  op = OP_ADD;
                    CH_MINUS: op = OP_SUB;
                    CH_STAR:  op = OP_MUL;
                    CH_SLASH: op = OP_DIV;
                    default:  op = OP_OTHER;
                endcase
                while (oper_cnt > 0 && prio(op) <= prio(oper_stk[oper_cnt - 1]))
                    reduce_top();
                if (oper_cnt >= DEPTH)
                    note_error(ERR_STACK);
                else
                begin
                    oper_stk[oper_cnt] = op;
                    oper_cnt++;
                end
            end
        end
        if (!last)
            return 1'b0;
        close_number();
        while (oper_cnt > 0)
            reduce_top();
        if (opnd_cnt == 0)
            note_error(ERR_STACK);
        else
            v = opnd_stk[opnd_cnt - 1];
        res.value = v[VAL_W-1:0];
        res.err   = first_err;
        opnd_cnt  = 0;
        oper_cnt  = 0;
        num_acc   = '0;
        num_open  = 1'b0;
        first_err = ERR_NONE;
        return 1'b1;
    endfunction

    // ---- stimulus ----------------------------------------------------------

    function automatic void enqueue_word(logic [CHAR_W-1:0] ch, logic last, int ph, bit drain);
        char_word_t w;
        w.ch    = ch;
        w.last  = last;
        w.phase = ph;
        w.drain = drain;
        char_queue.push_back(w);
    endfunction

    function automatic void push_text(string s);
        for (int i = 0; i < s.len(); i++)
            enqueue_word(s[i], i == s.len() - 1, 0, 1'b0);
    endfunction

    function automatic logic [CHAR_W-1:0] pick_operator();
        int r;
        r = $urandom_range(0, 99);
        if (r < 3)
            return CH_HASH;
        if (r < 6)
            return CH_DOLLAR;
        case (r % 4)
            0: return CH_PLUS;
            1: return CH_MINUS;
            2: return CH_STAR;
            default: return CH_SLASH;
        endcase
    endfunction

    function automatic void make_expression(int ph, bit drain);
        logic [CHAR_W-1:0] text[$];
        int r;
        int n_opnd;
        int n_dig;
        r = $urandom_range(0, 99);
        if (r < 15)
        begin
            repeat ($urandom_range(1, 6))
                text.push_back(CHAR_W'($urandom_range(0, 255)));
        end
        else
        begin
            n_opnd = $urandom_range(1, 4);
            for (int k = 0; k < n_opnd; k++)
            begin
                if ($urandom_range(0, 4) == 0)
                    text.push_back(CH_SPACE);
                n_dig = $urandom_range(0, 99);
                n_dig = n_dig < 3 ? 10 : n_dig < 12 ? 5 : $urandom_range(1, 3);
                repeat (n_dig)
                    text.push_back(CH_ZERO + CHAR_W'($urandom_range(0, 9)));
                if (k < n_opnd - 1)
                begin
                    if ($urandom_range(0, 3) == 0)
                        text.push_back(CH_SPACE);
                    text.push_back(pick_operator());
                end
            end
            // broken tail: dangling operator or stray space
            if (r < 25)
                text.push_back(pick_operator());
            else if (r < 30)
                text.push_back(CH_SPACE);
        end
        foreach (text[i])
            enqueue_word(text[i], i == text.size() - 1, ph, drain && i == 0);
    endfunction

    // ---- driver ------------------------------------------------------------

    always @(posedge clk)
    begin : drive_chars
        char_word_t   head;
        expr_result_t res;
        bit           taken;
        bit           offer;
        int           idle_pct;
        if (rst_n)
        begin
            taken = s_tvalid && s_tready;
            if (taken)
            begin
                head = char_queue.pop_front();
                chars_sent++;
                if (evaluate_char(head.ch, head.last, res))
                    predicted_results.push_back(res);
            end
            if (s_tvalid && !taken)
                offer = 1'b1;
            else if (char_queue.size() == 0)
                offer = 1'b0;
            else
            begin
                head = char_queue[0];
                idle_pct = head.phase == 0 ? 20 : head.phase == 1 ? 75 : 0;
                if (head.drain && predicted_results.size() != 0)
                    offer = 1'b0;
                else
                    offer = $urandom_range(0, 99) >= idle_pct;
            end
            s_tvalid <= offer;
            if (offer)
            begin
                s_tdata <= char_queue[0].ch;
                s_tlast <= char_queue[0].last;
                phase   <= char_queue[0].phase;
            end
        end
    end

    // ---- monitor -----------------------------------------------------------

    always @(posedge clk)
    begin : check_results
        expr_result_t            want;
        logic signed [VAL_W-1:0] got_val;
        logic [ERR_W-1:0]        got_err;
        int                      stall_pct;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got_val = m_tdata[VAL_W-1:0];
                got_err = m_tdata[VAL_W+ERR_W-1:VAL_W];
                if (predicted_results.size() == 0)
                begin
                    $error("result word with none pending: value %0d error_code %0d",
                           got_val, got_err);
                    failures++;
                end
                else
                begin
                    want = predicted_results.pop_front();
                    results_checked++;
                    err_seen[want.err]++;
                    if (got_val !== want.value)
                    begin
                        $error("value: expected %0d, got %0d", want.value, got_val);
                        failures++;
                    end
                    if (got_err !== want.err)
                    begin
                        $error("error_code: expected %0d, got %0d", want.err, got_err);
                        failures++;
                    end
                end
            end
            stall_pct = phase == 0 ? 75 : phase == 1 ? 20 : 0;
            m_tready <= $urandom_range(0, 99) >= stall_pct;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // ---- sequence ----------------------------------------------------------

    initial
    begin
        int start_size;
        // precedence, add, multiply and divide, divide by zero
        push_text("1+2*3/0");
        // missing operands, '$' as an operator
        push_text("9-$");
        enqueue_word(CH_NUL, 1'b1, 0, 1'b0);
        // operand stack full, '#' as an operator
        push_text("1 2 3 4#5");
        // number too large
        push_text("9999999999");
        enqueue_word(CH_TOP, 1'b1, 0, 1'b0);
        push_text(" ");
        for (int ph = 0; ph < 3; ph++)
        begin
            start_size = char_queue.size();
            make_expression(ph, ph != 0);
            while (char_queue.size() - start_size < PHASE_WORDS)
                make_expression(ph, 1'b0);
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (char_queue.size() != 0 || predicted_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("summary: %0d characters sent, %0d expressions checked", chars_sent,
                 results_checked);
        $display("summary: error codes seen ok %0d, div0 %0d, stack %0d, overflow %0d",
                 err_seen[0], err_seen[1], err_seen[2], err_seen[3]);
        if (failures == 0 && predicted_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

### infix_expression_evaluator.f
+incdir+rtl
rtl/iee_pkg.sv
rtl/iee_alu.sv
rtl/infix_expression_evaluator.sv
test/infix_expression_evaluator_test.sv
